// ----- design/swql_pkg.sv -----
// Shared widths, register indexes and defaults for the sliding-window quota limiter.
package swql_pkg;

    localparam int AMOUNT_W      = 16;
    localparam int TIME_W        = 32;
    localparam int QUOTA_W       = 21;
    localparam int WINDOW_W      = 16;
    localparam int SUM_W         = QUOTA_W;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = QUOTA_W;
    localparam int LOG_DEPTH_DEF = 16;
    localparam int ENTRY_W       = AMOUNT_W + TIME_W;

    localparam logic [CFG_INDEX_W-1:0] REG_QUOTA  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 1'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1;

endpackage

// ----- design/sliding_window_quota_limiter.sv -----
// Sliding-window quota limiter: a logged ring of grants, expired one entry per cycle.
// After a beat is accepted, up to LOG_DEPTH expired entries are removed in S_EXP, one per
// cycle through the shared adder; S_DEC and S_HOLD follow, and the result is registered
// once the output is free. A new request is stalled until the previous result is issued.
// Reset (synchronous, active low) empties the log and sets the amount limit to 0 and
// window_seconds to 1; the log memory itself is not cleared.
module sliding_window_quota_limiter
    import swql_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [AMOUNT_W-1:0]     i_amount,
    input  logic [TIME_W-1:0]       i_now_seconds,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_granted,
    output logic                    o_log_full
);

    localparam int IDX_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LOG_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXP  = 4'b0010,
        S_DEC  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [QUOTA_W-1:0]      r_quota;
    logic [WINDOW_W-1:0]     r_window;
    logic [IDX_W-1:0]        r_oldest, n_oldest;
    logic [IDX_W-1:0]        r_next, n_next;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [AMOUNT_W-1:0]     r_amount;
    logic [TIME_W-1:0]       r_now;
    logic                    r_out_valid, n_out_valid;
    logic                    r_granted, n_granted;
    logic                    r_full, n_full;

    logic [ENTRY_W-1:0]      ent_rdata;
    logic [AMOUNT_W-1:0]     ent_amount;
    logic [TIME_W-1:0]       ent_time;
    logic [TIME_W-1:0]       age;
    logic                    expired;
    logic [AMOUNT_W-1:0]     addend;
    logic [SUM_W:0]          alu_res;
    logic                    ram_we;
    logic                    in_accept;
    logic                    out_free;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign ent_amount = ent_rdata[ENTRY_W-1:TIME_W];
    assign ent_time   = ent_rdata[TIME_W-1:0];
    assign age        = r_now - ent_time;
    assign expired    = (r_count != '0) && (age >= TIME_W'(r_window));

    // One adder serves both the expiry subtraction and the quota check.
    assign addend  = (r_state == S_EXP) ? ent_amount : r_amount;
    assign alu_res = (r_state == S_EXP) ? ({1'b0, r_sum} - (SUM_W + 1)'(addend))
                                        : ({1'b0, r_sum} + (SUM_W + 1)'(addend));

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_next      = r_next;
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_full      = r_full;
        ram_we      = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (expired) begin
                    n_sum    = alu_res[SUM_W-1:0];
                    n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
                    n_count  = r_count - 1'b1;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_granted   = 1'b0;
                    n_full      = 1'b0;
                    n_state     = S_IDLE;
                    if (r_count == FULL_CNT) begin
                        n_full = 1'b1;
                    end else if (alu_res <= (SUM_W + 1)'(r_quota)) begin
                        n_granted = 1'b1;
                        ram_we    = 1'b1;
                        n_sum     = alu_res[SUM_W-1:0];
                        n_next    = (r_next == LAST_SLOT) ? '0 : r_next + 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quota     <= '0;
            r_window    <= WINDOW_RESET;
            r_oldest    <= '0;
            r_next      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next      <= n_next;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_QUOTA:  r_quota  <= i_cfg_data;
                    REG_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_amount <= i_amount;
            r_now    <= i_now_seconds;
        end
        r_granted <= n_granted;
        r_full    <= n_full;
    end

    // The read address follows the next oldest slot, so the registered read data holds its entry.
    swql_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next),
        .i_wdata ({r_amount, r_now}),
        .i_raddr (n_oldest),
        .o_rdata (ent_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_log_full  = r_full;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("log entry count exceeds the log depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_granted && r_full))
        else $error("a request is both granted and flagged as log full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result beat raised outside the decision step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP && expired) |=> (r_count == $past(r_count) - 1'b1))
        else $error("expiry step did not drop exactly one entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count != FULL_CNT))
        else $error("log written while full");

endmodule

// ----- design/swql_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module swql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/tb_sliding_window_quota_limiter.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window quota limiter with a built-in request log predictor.
module tb_sliding_window_quota_limiter;
    import swql_pkg::*;

    localparam int          DEPTH             = LOG_DEPTH_DEF;
    localparam int unsigned RESULT_WAIT_LIMIT = 4000;
    localparam int unsigned MAX_PRINTED       = 200;

    typedef struct packed {
        logic granted;
        logic log_full;
    } t_verdict;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [AMOUNT_W-1:0]    i_amount      = '0;
    logic [TIME_W-1:0]      i_now_seconds = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic                   o_granted;
    logic                   o_log_full;

    // Predicted limiter state and its copy of the registers.
    logic [AMOUNT_W-1:0]     log_amount [DEPTH];
    logic [TIME_W-1:0]       log_time   [DEPTH];
    int unsigned             log_head     = 0;
    int unsigned             log_tail     = 0;
    int unsigned             log_count    = 0;
    int unsigned             logged_sum   = 0;
    logic [QUOTA_W-1:0]      quota_limit  = '0;
    logic [WINDOW_W-1:0]     window_len   = WINDOW_RESET;

    t_verdict    expected_verdicts [$];
    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned burst_left     = 0;
    int unsigned stall_level    = 0;
    int unsigned stall_left     = 0;

    sliding_window_quota_limiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_amount      (i_amount),
        .i_now_seconds (i_now_seconds),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_granted     (o_granted),
        .o_log_full    (o_log_full)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("** sliding_window_quota_limiter: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic t_verdict predict_verdict(input logic [AMOUNT_W-1:0] amt,
                                                 input logic [TIME_W-1:0] now);
        t_verdict          v;
        logic [TIME_W-1:0] age;
        bit                inside_window;
        v = '0;
        inside_window = 1'b0;
        while (log_count > 0 && !inside_window) begin
            age = now - log_time[log_head];
            if (age < {16'd0, window_len}) begin
                inside_window = 1'b1;
            end else begin
                logged_sum -= log_amount[log_head];
                log_head = (log_head + 1) % DEPTH;
                log_count--;
            end
        end
        if (log_count >= DEPTH) begin
            v.log_full = 1'b1;
        end else if (logged_sum + amt <= quota_limit) begin
            log_amount[log_tail] = amt;
            log_time[log_tail] = now;
            log_tail = (log_tail + 1) % DEPTH;
            log_count++;
            logged_sum += amt;
            v.granted = 1'b1;
        end
        return v;
    endfunction

    task automatic send_request(input logic [AMOUNT_W-1:0] amt, input logic [TIME_W-1:0] now);
        t_verdict v;
        i_in_valid    <= 1'b1;
        i_amount      <= amt;
        i_now_seconds <= now;
        do @(posedge i_clk); while (o_in_stall);
        v = predict_verdict(amt, now);
        expected_verdicts = {expected_verdicts, v};
    endtask

    task automatic wait_for_results();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (expected_verdicts.size() != 0 && waited < RESULT_WAIT_LIMIT);
        if (expected_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
            expected_verdicts.delete();
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (reg_index == REG_QUOTA) begin
            quota_limit = value[QUOTA_W-1:0];
        end else if (reg_index == REG_WINDOW) begin
            window_len = value[WINDOW_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic configure_limits(input logic [QUOTA_W-1:0] max_total,
                                    input logic [WINDOW_W-1:0] win);
        write_register(REG_QUOTA, max_total);
        write_register(REG_WINDOW, {{(CFG_DATA_W - WINDOW_W){1'b0}}, win});
    endtask

    task automatic pace_sender(input bit paced);
        int unsigned gap;
        if ($urandom_range(0, 99) < 2) begin
            wait_for_results();
        end else if (paced) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int unsigned r;
        int unsigned cap;
        int unsigned full_cap;
        r = $urandom_range(0, 99);
        cap = quota_limit / 8 + 1;
        if (cap > 65535) begin
            cap = 65535;
        end
        full_cap = (quota_limit > 65535) ? 65535 : quota_limit;
        if (r < 10) begin
            return '0;
        end else if (r < 15) begin
            return '1;
        end else if (r < 40) begin
            return AMOUNT_W'($urandom_range(0, 15));
        end else if (r < 70) begin
            return AMOUNT_W'($urandom_range(0, cap));
        end else if (r < 85) begin
            return AMOUNT_W'($urandom_range(0, full_cap));
        end
        return AMOUNT_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] pick_time_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end else if (r < 30) begin
            return 1;
        end else if (r < 70) begin
            return $urandom_range(0, window_len / 12 + 1);
        end else if (r < 75) begin
            return {16'd0, window_len};
        end else if (r < 80) begin
            return {16'd0, window_len} - 1;
        end else if (r < 95) begin
            return $urandom_range(0, 2 * window_len + 2);
        end
        return $urandom;
    endfunction

    task automatic pick_limits();
        logic [QUOTA_W-1:0]  max_total;
        logic [WINDOW_W-1:0] win;
        case ($urandom_range(0, 5))
            0: max_total = '0;
            1: max_total = QUOTA_W'(1);
            2: max_total = QUOTA_W'($urandom_range(0, 1000));
            3: max_total = QUOTA_W'($urandom_range(0, 300000));
            4: max_total = '1;
            default: max_total = QUOTA_W'($urandom_range(0, 2097151));
        endcase
        case ($urandom_range(0, 5))
            0: win = WINDOW_W'(1);
            1: win = WINDOW_W'($urandom_range(2, 20));
            2: win = WINDOW_W'($urandom_range(1, 65535));
            3: win = '1;
            4: win = WINDOW_W'($urandom_range(20, 2000));
            default: win = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'd10;
        endcase
        configure_limits(max_total, win);
    endtask

    task automatic test_reset_defaults();
        send_request(16'd0, 32'd5);
        send_request(16'd1, 32'd5);
        wait_for_results();
    endtask

    task automatic test_quota_boundary();
        configure_limits(21'd100, 16'hFFFF);
        send_request(16'd60, 32'd0);
        send_request(16'd40, 32'd0);
        send_request(16'd1, 32'd0);
        send_request(16'd0, 32'd0);
        wait_for_results();
    endtask

    task automatic test_full_log();
        int i;
        configure_limits('1, 16'd20);
        for (i = 0; i < DEPTH; i++) begin
            send_request((i == 0) ? 16'hFFFF : 16'(i), 32'd1000000 + i);
        end
        send_request(16'd0, 32'd1000019);
        send_request(16'd0, 32'd1000020);
        wait_for_results();
    endtask

    task automatic test_time_wrap();
        configure_limits('1, 16'd100);
        send_request(16'd7, 32'hFFFF_FFF0);
        send_request(16'd3, 32'h0000_0005);
        send_request(16'd1, 32'hFFFF_FF00);
    endtask

    task automatic test_out_of_order_times();
        send_request(16'd1, 32'd200);
        send_request(16'd1, 32'd250);
        send_request(16'd1, 32'd210);
        wait_for_results();
    endtask

    task automatic test_zero_window();
        configure_limits(21'd10, 16'd0);
        send_request(16'd10, 32'd300);
        send_request(16'd10, 32'd300);
        wait_for_results();
    endtask

    task automatic test_lower_quota();
        configure_limits(21'd100, 16'd1000);
        send_request(16'd60, 32'd400);
        wait_for_results();
        write_register(REG_QUOTA, 21'd50);
        send_request(16'd0, 32'd401);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned total);
        int unsigned       sent;
        int unsigned       phase_len;
        int unsigned       n;
        int unsigned       style;
        bit                paced;
        logic [TIME_W-1:0] clock_now;
        sent = 0;
        while (sent < total) begin
            wait_for_results();
            pick_limits();
            phase_len = $urandom_range(30, 160);
            paced = ($urandom_range(0, 3) != 0);
            clock_now = $urandom;
            for (n = 0; n < phase_len && sent < total; n++) begin
                style = $urandom_range(0, 99);
                if (style < 85) begin
                    clock_now += pick_time_step();
                    send_request(pick_amount(), clock_now);
                end else if (style < 93) begin
                    // Arbitrary jump, often backwards once wrapped.
                    clock_now += $urandom;
                    send_request(pick_amount(), clock_now);
                end else begin
                    send_request(AMOUNT_W'($urandom), $urandom);
                end
                sent++;
                pace_sender(paced);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 4))
                0, 1: stall_level = 0;
                2: stall_level = 30;
                3: stall_level = 70;
                default: stall_level = 95;
            endcase
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        i_out_stall <= ($urandom_range(1, 100) <= stall_level);
    end

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result granted=%0b log_full=%0b",
                                          o_granted, o_log_full));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_granted !== want.granted) begin
                    report_mismatch($sformatf("result %0d: granted %0b, expected %0b",
                                              result_count, o_granted, want.granted));
                end
                if (o_log_full !== want.log_full) begin
                    report_mismatch($sformatf("result %0d: log_full %0b, expected %0b",
                                              result_count, o_log_full, want.log_full));
                end
            end
            result_count++;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_quota_boundary();
        test_full_log();
        test_time_wrap();
        test_out_of_order_times();
        test_zero_window();
        test_lower_quota();
        test_random_traffic(1800);

        wait_for_results();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** sliding_window_quota_limiter: PASSED **");
        end else begin
            $display("** sliding_window_quota_limiter: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/swql_pkg.sv
design/swql_ram.sv
design/sliding_window_quota_limiter.sv
tb/tb_sliding_window_quota_limiter.sv
